FILE: rtl/core/ethrx_pkg.sv
// Shared types, constants and CRC function for the Ethernet receive frame checker.
`timescale 1ns / 1ps
package ethrx_pkg;

  localparam int unsigned MaxCountDef = 2047;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned MacW        = 48;
  localparam int unsigned TypeW       = 16;
  localparam int unsigned LenW        = 11;
  localparam int unsigned CrcW        = 32;
  localparam int unsigned FcsBytes    = 4;
  localparam int unsigned AddrBytes   = 6;
  localparam int unsigned SrcEnd      = 12;
  localparam int unsigned TypeLoPos   = 12;
  localparam int unsigned TypeHiPos   = 13;
  localparam int unsigned MinFrame    = 18;
  localparam int unsigned LenCap      = 2047;

  localparam logic [CrcW-1:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] CrcPreset = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StCrcErr  = 2'd1,
    StAddrErr = 2'd2,
    StShort   = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } rx_item_t;

  typedef struct packed {
    status_e          status;
    logic [MacW-1:0]  src_mac;
    logic [TypeW-1:0] ether_type;
    logic [LenW-1:0]  length;
  } result_t;

  // Byte-wide update of the reflected CRC-32.
  function automatic logic [CrcW-1:0] crc32_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [CrcW-1:0] r;
    r = crc ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      r = (r >> 1) ^ (r[0] ? CrcPoly : '0);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/ethrx_in_stage.sv
// Input register with valid/ready handshake for received frame bytes.
`timescale 1ns / 1ps
module ethrx_in_stage
  import ethrx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rx_item_t item_i,
  input  logic     adv_i,
  output logic     vld_o,
  output rx_item_t item_o
);

  logic     vld_q, vld_d;
  rx_item_t item_q;
  logic     take;

  assign in_ready_o = !vld_q || adv_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

FILE: rtl/core/ethrx_frame_state.sv
// Per-frame state: CRC, FCS delay line, byte count, address check and field capture.
`timescale 1ns / 1ps
module ethrx_frame_state
  import ethrx_pkg::*;
#(
  parameter int unsigned MAX_COUNT = MaxCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            proc_i,
  input  rx_item_t        item_i,
  input  logic [MacW-1:0] station_mac_i,
  output result_t         result_o
);

  localparam int unsigned CntW = $clog2(MAX_COUNT + 1);
  localparam int unsigned ExtW = (CntW > LenW) ? CntW : LenW;

  logic [CntW-1:0]              cnt_q, cnt_d, cnt_n;
  logic [CrcW-1:0]              crc_q, crc_d, crc_n;
  logic [FcsBytes-1:0][ByteW-1:0] dly_q, dly_d, dly_n;
  logic                         match_q, match_d, match_n;
  logic [MacW-1:0]              src_q, src_d, src_n;
  logic [TypeW-1:0]             type_q, type_d, type_n;
  logic [2:0]                   addr_idx;
  logic [ByteW-1:0]             want;
  logic [ExtW-1:0]              cnt_ext;
  logic                         crc_ok;

  // Destination byte N is checked against station_mac[47-8N -: 8].
  assign addr_idx = 3'(AddrBytes - 1) - cnt_q[2:0];
  assign want     = station_mac_i[{addr_idx, 3'b000} +: ByteW];

  always_comb begin
    crc_n   = crc_q;
    match_n = match_q;
    src_n   = src_q;
    type_n  = type_q;
    cnt_n   = cnt_q;
    if (cnt_q >= CntW'(FcsBytes)) begin
      crc_n = crc32_byte(crc_q, dly_q[0]);
    end
    dly_n = {item_i.data, dly_q[FcsBytes-1:1]};
    if (cnt_q < CntW'(AddrBytes)) begin
      if (want != item_i.data) begin
        match_n = 1'b0;
      end
    end else if (cnt_q < CntW'(SrcEnd)) begin
      src_n = {src_q[MacW-ByteW-1:0], item_i.data};
    end else if (cnt_q == CntW'(TypeLoPos)) begin
      type_n[ByteW-1:0] = item_i.data;
    end else if (cnt_q == CntW'(TypeHiPos)) begin
      type_n[TypeW-1:ByteW] = item_i.data;
    end
    if (cnt_q != CntW'(MAX_COUNT)) begin
      cnt_n = cnt_q + 1'b1;
    end
  end

  assign crc_ok  = (dly_n == ~crc_n);
  assign cnt_ext = ExtW'(cnt_n);

  always_comb begin
    if (cnt_n < CntW'(MinFrame)) begin
      result_o.status = StShort;
    end else if (!crc_ok) begin
      result_o.status = StCrcErr;
    end else if (!match_n) begin
      result_o.status = StAddrErr;
    end else begin
      result_o.status = StOk;
    end
    result_o.src_mac    = src_n;
    result_o.ether_type = type_n;
    result_o.length     = (cnt_ext > ExtW'(LenCap)) ? LenW'(LenCap) : cnt_ext[LenW-1:0];
  end

  // Drop back to the preset values once the last byte is processed.
  always_comb begin
    if (item_i.last) begin
      cnt_d   = '0;
      crc_d   = CrcPreset;
      dly_d   = '0;
      match_d = 1'b1;
      src_d   = '0;
      type_d  = '0;
    end else begin
      cnt_d   = cnt_n;
      crc_d   = crc_n;
      dly_d   = dly_n;
      match_d = match_n;
      src_d   = src_n;
      type_d  = type_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      crc_q   <= CrcPreset;
      dly_q   <= '0;
      match_q <= 1'b1;
      src_q   <= '0;
      type_q  <= '0;
    end else if (proc_i) begin
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      dly_q   <= dly_d;
      match_q <= match_d;
      src_q   <= src_d;
      type_q  <= type_d;
    end
  end

endmodule

FILE: rtl/core/ethrx_out_stage.sv
// Result register with valid/ready handshake for frame reports.
`timescale 1ns / 1ps
module ethrx_out_stage
  import ethrx_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

FILE: rtl/core/ethernet_rx_frame_checker.sv
// Top level of the Ethernet receive frame checker.
// Takes one frame byte per cycle with an end-of-frame mark, checks the trailing
// FCS against a reflected CRC-32 of the rest of the frame, checks the destination
// address against the station MAC, and reports one result per frame: status
// (0 ok, 1 CRC error, 2 address mismatch, 3 shorter than 18 bytes), source MAC,
// type field and length. The report for a frame is loaded into the result register
// as its last byte leaves the input register. The pace is set by the byte-wide CRC
// update, done between the input and result registers. Bytes keep flowing while a
// report waits; only a further last byte stalls until the pending report is
// taken. Write the station MAC only between frames.
`timescale 1ns / 1ps
module ethernet_rx_frame_checker
  import ethrx_pkg::*;
#(
  parameter int unsigned MAX_COUNT = MaxCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [MacW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             end_of_frame_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [MacW-1:0]  source_mac_o,
  output logic [TypeW-1:0] ether_type_o,
  output logic [LenW-1:0]  frame_length_o
);

  logic [MacW-1:0] station_mac_q;
  rx_item_t        in_item, cur_item;
  logic            cur_vld, adv, out_free;
  result_t         res_comb, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_mac_q <= '0;
    end else if (cfg_valid_i) begin
      station_mac_q <= cfg_data_i;
    end
  end

  assign in_item.data = rx_byte_i;
  assign in_item.last = end_of_frame_i;

  // Hold a last byte until the result register can take its report.
  assign adv = cur_vld && (!cur_item.last || out_free);

  ethrx_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .vld_o      (cur_vld),
    .item_o     (cur_item)
  );

  ethrx_frame_state #(
    .MAX_COUNT (MAX_COUNT)
  ) u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .proc_i        (adv),
    .item_i        (cur_item),
    .station_mac_i (station_mac_q),
    .result_o      (res_comb)
  );

  ethrx_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && cur_item.last),
    .result_i    (res_comb),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res_out)
  );

  assign status_o       = res_out.status;
  assign source_mac_o   = res_out.src_mac;
  assign ether_type_o   = res_out.ether_type;
  assign frame_length_o = res_out.length;

endmodule

FILE: test/ethernet_rx_frame_checker_test.sv
// Testbench for the Ethernet receive frame checker: frame stimulus, prediction and checks.
`timescale 1ns / 1ps
module ethernet_rx_frame_checker_test;
  import ethrx_pkg::*;

  localparam int unsigned NumRows      = 14;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned PhaseBytes   = 230;
  localparam int unsigned PhaseFrames  = 6;

  typedef enum logic [1:0] {
    FillRandom = 2'd0,
    FillZero   = 2'd1,
    FillOnes   = 2'd2
  } fill_e;

  typedef struct packed {
    logic             set_station;
    logic [MacW-1:0]  station;
    logic [11:0]      length;
    fill_e            fill;
    logic             bad_dest;
    logic             bad_fcs;
    status_e          status;
    logic [LenW-1:0]  exp_len;
  } frame_row_t;

  typedef struct packed {
    logic            known;
    status_e         status;
    logic [LenW-1:0] length;
  } report_hint_t;

  // Lengths count the FCS; the last two columns are the report's status and length.
  localparam frame_row_t DirectedRows [NumRows] = '{
    '{1'b0, 48'h0, 12'd64, FillZero, 1'b0, 1'b0, StOk, 11'd64},
    '{1'b0, 48'h0, 12'd1, FillZero, 1'b0, 1'b0, StShort, 11'd1},
    '{1'b0, 48'h0, 12'd17, FillRandom, 1'b0, 1'b0, StShort, 11'd17},
    '{1'b0, 48'h0, 12'd18, FillRandom, 1'b0, 1'b0, StOk, 11'd18},
    '{1'b0, 48'h0, 12'd18, FillRandom, 1'b0, 1'b1, StCrcErr, 11'd18},
    '{1'b0, 48'h0, 12'd60, FillRandom, 1'b1, 1'b0, StAddrErr, 11'd60},
    '{1'b0, 48'h0, 12'd60, FillRandom, 1'b1, 1'b1, StCrcErr, 11'd60},
    '{1'b0, 48'h0, 12'd10, FillRandom, 1'b0, 1'b1, StShort, 11'd10},
    '{1'b1, 48'hFFFF_FFFF_FFFF, 12'd64, FillOnes, 1'b0, 1'b0, StOk, 11'd64},
    '{1'b0, 48'h0, 12'd4, FillRandom, 1'b0, 1'b0, StShort, 11'd4},
    '{1'b0, 48'h0, 12'd19, FillZero, 1'b0, 1'b1, StCrcErr, 11'd19},
    '{1'b0, 48'h0, 12'd64, FillRandom, 1'b1, 1'b0, StAddrErr, 11'd64},
    '{1'b0, 48'h0, 12'd13, FillRandom, 1'b0, 1'b0, StShort, 11'd13},
    '{1'b0, 48'h0, 12'd7, FillRandom, 1'b1, 1'b0, StShort, 11'd7}
  };

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [MacW-1:0]  cfg_data_i     = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] rx_byte_i      = '0;
  logic             end_of_frame_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic [1:0]       status_o;
  logic [MacW-1:0]  source_mac_o;
  logic [TypeW-1:0] ether_type_o;
  logic [LenW-1:0]  frame_length_o;

  // Predicted frame state
  logic [MacW-1:0]  station_addr = '0;
  logic [CrcW-1:0]  fcs_crc      = CrcPreset;
  logic [ByteW-1:0] fcs_hold [FcsBytes];
  int unsigned      rx_count     = 0;
  logic             dest_ok      = 1'b1;
  logic [MacW-1:0]  src_acc      = '0;
  logic [TypeW-1:0] type_acc     = '0;

  result_t      expected_reports [$];
  report_hint_t report_hints [$];
  int unsigned  error_count   = 0;
  int unsigned  stall_cycles  = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_requests = 0;
  int unsigned  hold_served   = 0;
  int unsigned  hold_left     = 0;

  ethernet_rx_frame_checker u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .source_mac_o   (source_mac_o),
    .ether_type_o   (ether_type_o),
    .frame_length_o (frame_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bit-serial reflected CRC-32, data LSB first.
  function automatic logic [CrcW-1:0] fold_crc_byte(input logic [CrcW-1:0] c,
                                                    input logic [ByteW-1:0] b);
    logic [CrcW-1:0] r;
    r = c;
    for (int i = 0; i < ByteW; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic void clear_frame();
    fcs_crc  = CrcPreset;
    for (int k = 0; k < FcsBytes; k++) fcs_hold[k] = '0;
    rx_count = 0;
    dest_ok  = 1'b1;
    src_acc  = '0;
    type_acc = '0;
  endfunction

  // Advance the predicted frame by one byte; return 1 when a report is due.
  function automatic bit absorb_byte(input logic [ByteW-1:0] b, input logic eof,
                                     output result_t rpt);
    int unsigned pos;
    logic        crc_ok;
    pos = rx_count;
    rpt = '0;
    if (pos >= FcsBytes) fcs_crc = fold_crc_byte(fcs_crc, fcs_hold[0]);
    for (int k = 0; k < FcsBytes - 1; k++) fcs_hold[k] = fcs_hold[k+1];
    fcs_hold[FcsBytes-1] = b;
    if (pos < AddrBytes) begin
      if (station_addr[8*(5-pos) +: 8] != b) dest_ok = 1'b0;
    end else if (pos < SrcEnd) begin
      src_acc = {src_acc[MacW-9:0], b};
    end else if (pos == TypeLoPos) begin
      type_acc[7:0] = b;
    end else if (pos == TypeHiPos) begin
      type_acc[15:8] = b;
    end
    if (rx_count < MaxCountDef) rx_count++;
    if (!eof) return 1'b0;
    crc_ok = {fcs_hold[3], fcs_hold[2], fcs_hold[1], fcs_hold[0]} == ~fcs_crc;
    if (rx_count < MinFrame) begin
      rpt.status = StShort;
    end else if (!crc_ok) begin
      rpt.status = StCrcErr;
    end else if (!dest_ok) begin
      rpt.status = StAddrErr;
    end else begin
      rpt.status = StOk;
    end
    rpt.src_mac    = src_acc;
    rpt.ether_type = type_acc;
    rpt.length     = LenW'((rx_count > LenCap) ? LenCap : rx_count);
    clear_frame();
    return 1'b1;
  endfunction

  initial clear_frame();

  // Predict on accepted requests, compare accepted reports.
  always @(posedge clk_i) begin : monitor
    result_t      rpt;
    result_t      want;
    report_hint_t hint;
    logic         progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        station_addr = cfg_data_i;
        progress = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        progress = 1'b1;
        if (expected_reports.size() == 0) begin
          $error("report with nothing pending: status %0d length %0d", status_o,
                 frame_length_o);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (source_mac_o !== want.src_mac) begin
            $error("source_mac: expected %h, got %h", want.src_mac, source_mac_o);
            error_count++;
          end
          if (ether_type_o !== want.ether_type) begin
            $error("ether_type: expected %h, got %h", want.ether_type, ether_type_o);
            error_count++;
          end
          if (frame_length_o !== want.length) begin
            $error("frame_length: expected %0d, got %0d", want.length, frame_length_o);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        progress = 1'b1;
        if (absorb_byte(rx_byte_i, end_of_frame_i, rpt)) begin
          hint = report_hints.pop_front();
          if (hint.known) begin
            rpt.status = hint.status;
            rpt.length = hint.length;
          end
          expected_reports.push_back(rpt);
        end
      end
      stall_cycles <= progress ? 0 : stall_cycles + 1;
    end
  end

  // Report side: random stalls, plus long hold-offs on request.
  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready_i <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HoldCycles;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    @(posedge rst_ni);
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eof);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    rx_byte_i      <= b;
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int unsigned len, input fill_e fill, input logic bad_dest,
                            input logic bad_fcs, input report_hint_t hint);
    logic [ByteW-1:0] body [$];
    logic [ByteW-1:0] b;
    logic [CrcW-1:0]  crc;
    int unsigned      body_len;
    int unsigned      k;
    body_len = (len >= FcsBytes) ? len - FcsBytes : len;
    for (k = 0; k < body_len; k++) begin
      if (k < AddrBytes) begin
        b = station_addr[8*(5-k) +: 8];
      end else begin
        case (fill)
          FillZero: b = 8'h00;
          FillOnes: b = 8'hFF;
          default:  b = ByteW'($urandom_range(255));
        endcase
      end
      body.push_back(b);
    end
    if (bad_dest && body_len > 0) begin
      k = $urandom_range(((body_len < AddrBytes) ? body_len : AddrBytes) - 1);
      body[k] = body[k] ^ (8'h01 << $urandom_range(7));
    end
    crc = CrcPreset;
    foreach (body[i]) crc = fold_crc_byte(crc, body[i]);
    crc = ~crc;
    if (bad_fcs) crc = crc ^ (32'h1 << $urandom_range(31));
    if (len >= FcsBytes) begin
      for (k = 0; k < FcsBytes; k++) body.push_back(crc[8*k +: 8]);
    end
    report_hints.push_back(hint);
    foreach (body[i]) send_byte(body[i], i == body.size() - 1);
  endtask

  // Write only with the block idle.
  task automatic write_station(input logic [MacW-1:0] mac);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mac;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    report_hint_t hint;
    logic [MacW-1:0] mac;
    int unsigned len;
    int unsigned pick;
    int unsigned bytes_sent;
    int unsigned frames_sent;
    fill_e fill;
    logic bad_dest;
    logic bad_fcs;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 55;
    for (int r = 0; r < NumRows; r++) begin
      if (DirectedRows[r].set_station) write_station(DirectedRows[r].station);
      hint = {1'b1, DirectedRows[r].status, DirectedRows[r].exp_len};
      send_frame(DirectedRows[r].length, DirectedRows[r].fill, DirectedRows[r].bad_dest,
                 DirectedRows[r].bad_fcs, hint);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 55 : 0;
      recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 33 : 0;
      mac[47:32] = 16'($urandom_range(16'hFFFF));
      mac[31:0]  = $urandom();
      write_station((phase == 1) ? '0 : mac);
      hint = '0;
      if (phase == 2) begin
        // Hold off reports so that back-to-back frame ends stall the input.
        hold_requests++;
        for (int f = 0; f < 10; f++) begin
          send_frame($urandom_range(24, 1), FillRandom, 1'b0, 1'b0, hint);
        end
      end
      bytes_sent  = 0;
      frames_sent = 0;
      while (bytes_sent < PhaseBytes || frames_sent < PhaseFrames) begin
        pick     = $urandom_range(99);
        fill     = FillRandom;
        bad_dest = 1'b0;
        bad_fcs  = 1'b0;
        if (pick < 2) begin
          len     = $urandom_range(160, 100);
          bad_fcs = 1'($urandom_range(1));
        end else if (pick < 64) begin
          len = $urandom_range(80, 18);
        end else if (pick < 74) begin
          len     = $urandom_range(80, 18);
          bad_fcs = 1'b1;
        end else if (pick < 82) begin
          len      = $urandom_range(80, 18);
          bad_dest = 1'b1;
        end else if (pick < 89) begin
          len = $urandom_range(17, 1);
        end else begin
          len      = $urandom_range(40, 1);
          bad_dest = 1'($urandom_range(1));
          bad_fcs  = 1'($urandom_range(1));
        end
        send_frame(len, fill, bad_dest, bad_fcs, hint);
        bytes_sent  += len;
        frames_sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: ethernet_rx_frame_checker.f
rtl/core/ethrx_pkg.sv
rtl/core/ethrx_in_stage.sv
rtl/core/ethrx_frame_state.sv
rtl/core/ethrx_out_stage.sv
rtl/core/ethernet_rx_frame_checker.sv
test/ethernet_rx_frame_checker_test.sv
